@@ rtl/core/direction_to_aim_angles_macros.svh @@
// Assertion helpers for the aim-angle block checker.
// Both expect clk and arst_n in the scope where they are used.
`ifndef DIRECTION_TO_AIM_ANGLES_MACROS_SVH
`define DIRECTION_TO_AIM_ANGLES_MACROS_SVH

// Same-cycle implication.
`define DTAA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aim angle check failed");

// Next-cycle implication.
`define DTAA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aim angle check failed");

`endif

@@ rtl/core/dtaa_pkg.sv @@
`default_nettype none

package dtaa_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int FIELD_W = 16;
	localparam int FRAC_BITS = 14;
	localparam int ACC_W = 34;
	localparam int TURN_W = 32;
	localparam int UNITS_W = 15;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);

	localparam int GAIN_FRAC = 16;
	localparam logic [GAIN_FRAC-1:0] GAIN_INV_Q16 = 16'd39797;

	localparam logic [TURN_W-1:0] TURN_HALF = 32'h8000_0000;
	localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [15:0] UNITS_PER_TURN = 16'd46080;

	localparam logic [UNITS_W-1:0] X_QUARTER_UNITS = 15'd11520;
	localparam logic [UNITS_W-1:0] Y_HALF_UNITS = 15'd23040;
	localparam logic signed [15:0] ANG_X_MAX = 16'sd11520;
	localparam logic signed [16:0] ANG_Y_MAX = 17'sd23040;

	typedef struct packed {
		logic signed [FIELD_W-1:0] dir_x;
		logic signed [FIELD_W-1:0] dir_y;
		logic signed [FIELD_W-1:0] dir_z;
	} dtaa_vec_t;

	typedef struct packed {
		logic signed [14:0] x_axis_angle;
		logic signed [15:0] y_axis_angle;
		logic               zero_vector;
	} dtaa_aim_t;

	typedef struct packed {
		logic zero;
		logic on_y;
		logic x_pos;
		logic y_pos;
		logic y_neg;
	} dtaa_flags_t;

	function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		case (idx)
			0: atan_turn = 32'd536870912;
			1: atan_turn = 32'd316933406;
			2: atan_turn = 32'd167458907;
			3: atan_turn = 32'd85004756;
			4: atan_turn = 32'd42667331;
			5: atan_turn = 32'd21354465;
			6: atan_turn = 32'd10679838;
			7: atan_turn = 32'd5340245;
			8: atan_turn = 32'd2670163;
			9: atan_turn = 32'd1335087;
			10: atan_turn = 32'd667544;
			11: atan_turn = 32'd333772;
			12: atan_turn = 32'd166886;
			13: atan_turn = 32'd83443;
			14: atan_turn = 32'd41722;
			15: atan_turn = 32'd20861;
			16: atan_turn = 32'd10430;
			17: atan_turn = 32'd5215;
			18: atan_turn = 32'd2608;
			19: atan_turn = 32'd1304;
			20: atan_turn = 32'd652;
			21: atan_turn = 32'd326;
			22: atan_turn = 32'd163;
			23: atan_turn = 32'd81;
			default: atan_turn = '0;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dtaa_cell.sv @@
`default_nettype none

module dtaa_cell #(
	parameter int DW = 33,
	parameter int SW = 8,
	parameter int STEP = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           up_valid,
	input  logic signed [DW-1:0]           up_a,
	input  logic signed [DW-1:0]           up_b,
	input  logic signed [dtaa_pkg::ACC_W-1:0] up_acc,
	input  logic [SW-1:0]                  up_side,
	output logic                           valid,
	output logic signed [DW-1:0]           a,
	output logic signed [DW-1:0]           b,
	output logic signed [dtaa_pkg::ACC_W-1:0] acc,
	output logic [SW-1:0]                  side
);
	import dtaa_pkg::*;

	logic signed [DW-1:0] da;
	logic signed [DW-1:0] db;
	logic signed [DW-1:0] a_nx;
	logic signed [DW-1:0] b_nx;
	logic signed [ACC_W-1:0] acc_nx;
	logic signed [ACC_W-1:0] step_ang;

	assign da = up_b >>> STEP;
	assign db = up_a >>> STEP;
	assign step_ang = ACC_W'(atan_turn(ATAN_IDX_W'(STEP)));

	// rotate toward b = 0
	always_comb begin
		if (!up_b[DW-1]) begin
			a_nx = up_a + da;
			b_nx = up_b - db;
			acc_nx = up_acc + step_ang;
		end else begin
			a_nx = up_a - da;
			b_nx = up_b + db;
			acc_nx = up_acc - step_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a <= a_nx;
			b <= b_nx;
			acc <= acc_nx;
			side <= up_side;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dtaa_gain.sv @@
`default_nettype none

module dtaa_gain #(
	parameter int DW = 33
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] m,
	output logic signed [DW-1:0] scaled
);
	import dtaa_pkg::*;

	localparam int HI_W = DW - 1 - GAIN_FRAC;
	localparam int LO_P_W = 2 * GAIN_FRAC;
	localparam int HI_P_W = HI_W + GAIN_FRAC;

	logic [DW-2:0] mag_s1;
	logic [LO_P_W-1:0] lo_s2;
	logic [HI_P_W-1:0] hi_s2;
	logic [DW-1:0] sum;

	assign sum = DW'(hi_s2) + DW'(lo_s2[LO_P_W-1:GAIN_FRAC]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= m[DW-1] ? '0 : m[DW-2:0];
			lo_s2 <= LO_P_W'(mag_s1[GAIN_FRAC-1:0]) * LO_P_W'(GAIN_INV_Q16);
			hi_s2 <= HI_P_W'(mag_s1[DW-2:GAIN_FRAC]) * HI_P_W'(GAIN_INV_Q16);
			scaled <= signed'(sum);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dtaa_units.sv @@
`default_nettype none

module dtaa_units (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [dtaa_pkg::ACC_W-1:0]  acc,
	input  logic [dtaa_pkg::TURN_W-1:0]        limit,
	output logic [dtaa_pkg::UNITS_W-1:0]       units
);
	import dtaa_pkg::*;

	localparam int PROD_W = TURN_W + 16;

	logic [TURN_W-1:0] clip_s1;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc[ACC_W-1]) begin
				clip_s1 <= '0;
			end else if (acc > signed'(ACC_W'(limit))) begin
				clip_s1 <= limit;
			end else begin
				clip_s1 <= acc[TURN_W-1:0];
			end
			prod_s2 <= PROD_W'(clip_s1) * PROD_W'(UNITS_PER_TURN);
			units <= UNITS_W'((prod_s2 + PROD_W'(TURN_HALF)) >> TURN_W);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/direction_to_aim_angles.sv @@
`default_nettype none

// Direction vector to aim angles (yaw about y, pitch about x).
// Input channel vec: vec_valid / vec_stall with payload vec (dir_x, dir_y, dir_z).
// Output channel aim: aim_valid / aim_stall with payload aim
//   (x_axis_angle, y_axis_angle in 1/128 degree, zero_vector flag).
// An item moves on a rising edge with valid high and stall low.
// Throughput: one item per cycle while vec_stall is low; each item walks two rows
//   of CORDIC cells, one cell per iteration, with three-stage sections after each row:
//   gain and angle scaling after the first, angle scaling alone after the second.
// Every vector gives exactly one result, in order.
// When aim_stall holds a result, the pipeline keeps running until a one-item
//   skid register fills; then vec_stall rises and the whole pipeline holds.
// Reset clears every valid bit, those of the output and skid registers too;
//   data registers keep their contents; no clearing pass.
module direction_to_aim_angles #(
	parameter int COMPONENT_WIDTH = dtaa_pkg::COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STEPS = dtaa_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vec_valid,
	output logic                vec_stall,
	input  dtaa_pkg::dtaa_vec_t vec,
	output logic                aim_valid,
	input  logic                aim_stall,
	output dtaa_pkg::dtaa_aim_t aim
);
	import dtaa_pkg::*;

	localparam int W = COMPONENT_WIDTH;
	localparam int N = CORDIC_STEPS;
	localparam int DW = W + FRAC_BITS + 3;
	localparam int EXT_W = (W > FIELD_W) ? W : FIELD_W;
	localparam int FL_W = $bits(dtaa_flags_t);
	localparam int S1_W = FL_W + DW;
	localparam int S2_W = FL_W + UNITS_W;

	logic en;

	logic [EXT_W-1:0] ex;
	logic [EXT_W-1:0] ey;
	logic [EXT_W-1:0] ez;
	logic signed [W-1:0] cx;
	logic signed [W-1:0] cy;
	logic signed [W-1:0] cz;
	logic signed [DW-1:0] xe;
	logic signed [DW-1:0] ye;
	logic signed [DW-1:0] ze;
	logic signed [DW-1:0] ax;
	logic signed [DW-1:0] ay;
	logic signed [DW-1:0] sz;
	logic signed [DW-1:0] a0;
	logic signed [DW-1:0] b0;
	logic signed [ACC_W-1:0] acc0;
	dtaa_flags_t fl0;

	logic pre_valid_s1;
	logic signed [DW-1:0] pre_a_s1;
	logic signed [DW-1:0] pre_b_s1;
	logic signed [ACC_W-1:0] pre_acc_s1;
	logic [S1_W-1:0] pre_side_s1;

	logic p1_valid [N+1];
	logic signed [DW-1:0] p1_a [N+1];
	logic signed [DW-1:0] p1_b [N+1];
	logic signed [ACC_W-1:0] p1_acc [N+1];
	logic [S1_W-1:0] p1_side [N+1];

	logic mid_valid_s1;
	logic mid_valid_s2;
	logic mid_valid_s3;
	logic [S1_W-1:0] mid_side_s1;
	logic [S1_W-1:0] mid_side_s2;
	logic [S1_W-1:0] mid_side_s3;
	logic [UNITS_W-1:0] y_units;
	logic signed [DW-1:0] m_scaled;

	logic p2_valid [N+1];
	logic signed [DW-1:0] p2_a [N+1];
	logic signed [DW-1:0] p2_b [N+1];
	logic signed [ACC_W-1:0] p2_acc [N+1];
	logic [S2_W-1:0] p2_side [N+1];

	logic tl_valid_s1;
	logic tl_valid_s2;
	logic tl_valid_s3;
	logic [S2_W-1:0] tl_side_s1;
	logic [S2_W-1:0] tl_side_s2;
	logic [S2_W-1:0] tl_side_s3;
	logic [UNITS_W-1:0] x_units;

	dtaa_flags_t fl_t;
	logic [UNITS_W-1:0] ymag_t;
	logic [UNITS_W-1:0] xmag;
	logic [UNITS_W-1:0] ymag;
	dtaa_aim_t res;

	logic out_valid_q;
	logic sk_valid_q;
	dtaa_aim_t out_q;
	dtaa_aim_t sk_q;
	logic push;
	logic take;

	assign en = !sk_valid_q;
	assign vec_stall = sk_valid_q;

	assign ex = EXT_W'($unsigned(vec.dir_x));
	assign ey = EXT_W'($unsigned(vec.dir_y));
	assign ez = EXT_W'($unsigned(vec.dir_z));
	assign cx = signed'(ex[W-1:0]);
	assign cy = signed'(ey[W-1:0]);
	assign cz = signed'(ez[W-1:0]);
	assign xe = DW'(cx);
	assign ye = DW'(cy);
	assign ze = DW'(cz);
	assign ax = (xe[DW-1] ? -xe : xe) <<< FRAC_BITS;
	assign ay = (ye[DW-1] ? -ye : ye) <<< FRAC_BITS;
	assign sz = ze <<< FRAC_BITS;

	assign fl0.zero = (cx == '0) && (cy == '0) && (cz == '0);
	assign fl0.on_y = (cx == '0) && (cz == '0);
	assign fl0.x_pos = !cx[W-1] && (cx != '0);
	assign fl0.y_pos = !cy[W-1] && (cy != '0);
	assign fl0.y_neg = cy[W-1];

	// pre-rotate by -90 degrees when z is negative
	always_comb begin
		if (cz[W-1]) begin
			a0 = ax;
			b0 = -sz;
			acc0 = ACC_W'(TURN_QUARTER);
		end else begin
			a0 = sz;
			b0 = ax;
			acc0 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_s1 <= 1'b0;
		end else if (en) begin
			pre_valid_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_a_s1 <= a0;
			pre_b_s1 <= b0;
			pre_acc_s1 <= acc0;
			pre_side_s1 <= {fl0, ay};
		end
	end

	assign p1_valid[0] = pre_valid_s1;
	assign p1_a[0] = pre_a_s1;
	assign p1_b[0] = pre_b_s1;
	assign p1_acc[0] = pre_acc_s1;
	assign p1_side[0] = pre_side_s1;

	for (genvar k = 0; k < N; k++) begin : g_pass1
		dtaa_cell #(
			.DW(DW),
			.SW(S1_W),
			.STEP(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.up_valid(p1_valid[k]),
			.up_a(p1_a[k]),
			.up_b(p1_b[k]),
			.up_acc(p1_acc[k]),
			.up_side(p1_side[k]),
			.valid(p1_valid[k+1]),
			.a(p1_a[k+1]),
			.b(p1_b[k+1]),
			.acc(p1_acc[k+1]),
			.side(p1_side[k+1])
		);
	end

	dtaa_units u_yunits (
		.clk(clk),
		.en(en),
		.acc(p1_acc[N]),
		.limit(TURN_HALF),
		.units(y_units)
	);

	dtaa_gain #(
		.DW(DW)
	) u_gain (
		.clk(clk),
		.en(en),
		.m(p1_a[N]),
		.scaled(m_scaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_valid_s1 <= 1'b0;
			mid_valid_s2 <= 1'b0;
			mid_valid_s3 <= 1'b0;
		end else if (en) begin
			mid_valid_s1 <= p1_valid[N];
			mid_valid_s2 <= mid_valid_s1;
			mid_valid_s3 <= mid_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_side_s1 <= p1_side[N];
			mid_side_s2 <= mid_side_s1;
			mid_side_s3 <= mid_side_s2;
		end
	end

	assign p2_valid[0] = mid_valid_s3;
	assign p2_a[0] = m_scaled;
	assign p2_b[0] = signed'(mid_side_s3[DW-1:0]);
	assign p2_acc[0] = '0;
	assign p2_side[0] = {mid_side_s3[S1_W-1 -: FL_W], y_units};

	for (genvar k = 0; k < N; k++) begin : g_pass2
		dtaa_cell #(
			.DW(DW),
			.SW(S2_W),
			.STEP(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.up_valid(p2_valid[k]),
			.up_a(p2_a[k]),
			.up_b(p2_b[k]),
			.up_acc(p2_acc[k]),
			.up_side(p2_side[k]),
			.valid(p2_valid[k+1]),
			.a(p2_a[k+1]),
			.b(p2_b[k+1]),
			.acc(p2_acc[k+1]),
			.side(p2_side[k+1])
		);
	end

	dtaa_units u_xunits (
		.clk(clk),
		.en(en),
		.acc(p2_acc[N]),
		.limit(TURN_QUARTER),
		.units(x_units)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_valid_s1 <= 1'b0;
			tl_valid_s2 <= 1'b0;
			tl_valid_s3 <= 1'b0;
		end else if (en) begin
			tl_valid_s1 <= p2_valid[N];
			tl_valid_s2 <= tl_valid_s1;
			tl_valid_s3 <= tl_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_side_s1 <= p2_side[N];
			tl_side_s2 <= tl_side_s1;
			tl_side_s3 <= tl_side_s2;
		end
	end

	assign fl_t = dtaa_flags_t'(tl_side_s3[S2_W-1 -: FL_W]);
	assign ymag_t = tl_side_s3[UNITS_W-1:0];

	always_comb begin
		xmag = x_units;
		ymag = ymag_t;
		if (fl_t.on_y) begin
			xmag = X_QUARTER_UNITS;
			ymag = fl_t.y_neg ? Y_HALF_UNITS : '0;
		end
		res.zero_vector = fl_t.zero;
		res.y_axis_angle = fl_t.x_pos ? -signed'({1'b0, ymag}) : signed'({1'b0, ymag});
		res.x_axis_angle = fl_t.y_pos ? signed'(xmag) : -signed'(xmag);
		if (fl_t.zero) begin
			res.x_axis_angle = '0;
			res.y_axis_angle = '0;
		end
	end

	assign push = en && tl_valid_s3;
	assign take = out_valid_q && !aim_stall;

	// park in the skid register when the output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (take) begin
				sk_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				sk_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (take) begin
				out_q <= sk_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				sk_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign aim_valid = out_valid_q;
	assign aim = out_q;

endmodule

`default_nettype wire

@@ rtl/core/dtaa_checker.sv @@
`default_nettype none

`include "direction_to_aim_angles_macros.svh"

module dtaa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                vec_stall,
	input logic                aim_valid,
	input logic                aim_stall,
	input dtaa_pkg::dtaa_aim_t aim
);
	import dtaa_pkg::*;

	`DTAA_ASSERT_NEXT(a_hold, aim_valid && aim_stall, aim_valid && $stable(aim))
	`DTAA_ASSERT_NOW(a_zero, aim_valid && aim.zero_vector, aim.x_axis_angle == '0 && aim.y_axis_angle == '0)
	`DTAA_ASSERT_NOW(a_xrange, aim_valid, aim.x_axis_angle <= ANG_X_MAX && aim.x_axis_angle >= -ANG_X_MAX)
	`DTAA_ASSERT_NOW(a_yrange, aim_valid, aim.y_axis_angle <= ANG_Y_MAX && aim.y_axis_angle >= -ANG_Y_MAX)
	`DTAA_ASSERT_NOW(a_stall_cause, $rose(vec_stall), $past(aim_valid && aim_stall))

endmodule

bind direction_to_aim_angles dtaa_checker u_dtaa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.vec_stall(vec_stall),
	.aim_valid(aim_valid),
	.aim_stall(aim_stall),
	.aim(aim)
);

`default_nettype wire
